// ----- rtl/core/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("concurrent assertion failed (same cycle)");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("concurrent assertion failed (next cycle)");

`endif

// ----- rtl/core/jesl_pkg.sv -----
// -----------------------------------------------------------------------------
// jesl_pkg
// Shared widths, byte codes and the result record of the Exif segment locator.
// -----------------------------------------------------------------------------
package jesl_pkg;

   // Width of the byte position counter; the marker position is one bit wider.
   localparam int PosBits     = 32;
   localparam int NextBits    = PosBits + 1;
   localparam int SumBits     = PosBits + 2;
   localparam int OffsetBits  = 32;
   localparam int OffCalcBits = (SumBits > OffsetBits) ? SumBits : OffsetBits;
   localparam int WinLen      = 10;
   localparam int HistLen     = WinLen - 1;

   localparam logic [PosBits-1:0]  PosMax  = {PosBits{1'b1}};
   localparam logic [NextBits-1:0] NextMax = {NextBits{1'b1}};
   localparam logic [NextBits-1:0] FirstMarkerPos = NextBits'(2);

   // Byte codes of the JPEG marker walk.
   localparam logic [7:0] MarkerPrefix = 8'hFF;
   localparam logic [7:0] SoiCode      = 8'hD8;
   localparam logic [7:0] App1Code     = 8'hE1;
   localparam logic [7:0] AppClassMask = 8'hF0;
   localparam logic [7:0] AppClass     = 8'hE0;
   localparam logic [7:0] CharE        = 8'h45;
   localparam logic [7:0] CharX        = 8'h78;
   localparam logic [7:0] CharI        = 8'h69;
   localparam logic [7:0] CharF        = 8'h66;
   localparam logic [7:0] CharNul      = 8'h00;

   typedef struct packed {
      logic                  emit;
      logic                  found;
      logic [OffsetBits-1:0] tiff_offset;
   } jesl_result_type;

endpackage

// ----- rtl/core/jesl_walker.sv -----
// -----------------------------------------------------------------------------
// jesl_walker
// Marker walk state and the per-byte decision of the Exif segment locator.
// -----------------------------------------------------------------------------
module jesl_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output jesl_pkg::jesl_result_type result
);
   import jesl_pkg::*;

   logic [7:0]          hist_ff [HistLen];
   logic [7:0]          hist_in [HistLen];
   logic [PosBits-1:0]  pos_ff, pos_in;
   logic [NextBits-1:0] next_ff, next_in;
   logic                decided_ff, decided_in;

   logic [7:0]          win [WinLen];
   logic                hdr_fail, trigger, marker_bad, exif_ok;
   logic                fail_now, found_now, skip_now;
   logic [SumBits-1:0]  trig_pos, next_sum;
   logic [OffCalcBits-1:0] off_wide;

   // Window as seen after shifting in the current byte.
   always_comb begin
      for (int i = 0; i < HistLen; i++) begin
         win[i] = hist_ff[i];
      end
      win[HistLen] = data_byte;
   end

   always_comb begin
      hdr_fail = 1'b0;
      priority if (pos_ff == PosBits'(0)) begin
         hdr_fail = (data_byte != MarkerPrefix);
      end else if (pos_ff == PosBits'(1)) begin
         hdr_fail = (data_byte != SoiCode);
      end else if (pos_ff == PosBits'(2)) begin
         hdr_fail = (data_byte != MarkerPrefix);
      end else begin
         hdr_fail = 1'b0;
      end
   end

   assign trig_pos   = SumBits'(next_ff) + SumBits'(9);
   assign trigger    = (pos_ff != PosMax) && (SumBits'(pos_ff) == trig_pos);
   assign marker_bad = (win[0] != MarkerPrefix) || ((win[1] & AppClassMask) != AppClass);
   assign exif_ok    = (win[1] == App1Code) && (win[4] == CharE) && (win[5] == CharX) &&
                       (win[6] == CharI) && (win[7] == CharF) && (win[8] == CharNul) &&
                       (win[9] == CharNul);

   assign fail_now  = !decided_ff && (hdr_fail || (trigger && marker_bad));
   assign found_now = !decided_ff && !hdr_fail && trigger && !marker_bad && exif_ok;
   assign skip_now  = !decided_ff && !hdr_fail && trigger && !marker_bad && !exif_ok;

   // Next marker: current + big-endian length + 2, saturating.
   assign next_sum = SumBits'(next_ff) + SumBits'({win[2], win[3]}) + SumBits'(2);
   assign off_wide = OffCalcBits'(next_ff) + OffCalcBits'(10);

   always_comb begin
      result.emit        = !decided_ff && (fail_now || found_now || last_byte);
      result.found       = found_now;
      result.tiff_offset = found_now ? off_wide[OffsetBits-1:0] : '0;
   end

   always_comb begin
      for (int i = 0; i < HistLen - 1; i++) begin
         hist_in[i] = hist_ff[i+1];
      end
      hist_in[HistLen-1] = data_byte;
      pos_in     = pos_ff;
      next_in    = next_ff;
      decided_in = decided_ff || fail_now || found_now;
      if (skip_now) begin
         next_in = next_sum[SumBits-1] ? NextMax : next_sum[NextBits-1:0];
      end
      if (pos_ff != PosMax) begin
         pos_in = pos_ff + PosBits'(1);
      end
      // End of buffer: return to the reset state.
      if (last_byte) begin
         for (int i = 0; i < HistLen; i++) begin
            hist_in[i] = '0;
         end
         pos_in     = '0;
         next_in    = FirstMarkerPos;
         decided_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HistLen; i++) begin
            hist_ff[i] <= '0;
         end
         pos_ff     <= '0;
         next_ff    <= FirstMarkerPos;
         decided_ff <= 1'b0;
      end else if (step) begin
         hist_ff    <= hist_in;
         pos_ff     <= pos_in;
         next_ff    <= next_in;
         decided_ff <= decided_in;
      end
   end

endmodule

// ----- rtl/core/jpeg_exif_segment_locator_top.sv -----
// -----------------------------------------------------------------------------
// jpeg_exif_segment_locator_top
// Locates the Exif APP1 segment of a JPEG buffer streamed one byte per item.
// -----------------------------------------------------------------------------
//   channel | direction | tdata                    | tlast     | tuser
//   req_    | in        | [7:0] data_byte          | last_byte | -
//   rsp_    | out       | [31:0] tiff_offset       | -         | [0] found
//
// One byte per clock sustained while the sink keeps taking results: an item is
// registered on accept, decided by the marker walker once the output register
// has room, and its result, if any, lands in the output register behind rsp_tvalid.
// Each buffer gives exactly one result, early on a decision or at its last byte.
// Reset is synchronous and active high; it clears the walk state and both valids.
// A stalled result holds the output register; the input register then stalls too.
// -----------------------------------------------------------------------------
module jpeg_exif_segment_locator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [jesl_pkg::OffsetBits-1:0] rsp_tdata,  // [31:0] tiff_offset
   output logic        rsp_tuser    // [0] found
);
   import jesl_pkg::*;

   // Input register: one byte and its last flag.
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;

   // Output register: one result waiting for the sink.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_found_ff;
   logic [OffsetBits-1:0] out_offset_ff;

   logic                  advance;
   jesl_result_type       result;

   // Process the held byte whenever its possible result has a place to go.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   jesl_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   always_comb begin
      // Load a new byte, drop the processed one, else hold.
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      // Load a fresh result, drop a taken one, else hold.
      if (advance && result.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && result.emit) begin
         out_found_ff  <= result.found;
         out_offset_ff <= result.tiff_offset;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_offset_ff;
   assign rsp_tuser  = out_found_ff;

endmodule

// ----- rtl/core/jesl_checker.sv -----
// -----------------------------------------------------------------------------
// jesl_checker
// Port-level checks of the Exif segment locator, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module jesl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [jesl_pkg::OffsetBits-1:0]    rsp_tdata,
   input logic                               rsp_tuser
);
   import jesl_pkg::*;

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Not found always carries a zero offset.
   `ASSERT_SAME(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // A located segment lies past the SOI and the APP1 header.
   `ASSERT_SAME(a_hit_offset, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata >= OffsetBits'(12))

   // Reset empties the result register and the input register.
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind jpeg_exif_segment_locator_top jesl_checker u_jesl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_top.sv -----
// -----------------------------------------------------------------------------
// tb_top: Exif segment locator stream test
// Streams JPEG-like byte buffers into jpeg_exif_segment_locator_top and
// checks every located or not-located result. A byte-level predictor tracks
// the marker walk per accepted byte. Both sides idle at random.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jesl_pkg::*;

   localparam int RandomBytes = 1850;
   localparam int CycleLimit  = 400000;
   localparam int DrainCycles = 20;
   localparam int ReportLimit = 10;

   // One input item: a buffer byte and its end-of-buffer flag.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   // One result item as the block reports it.
   typedef struct packed {
      logic                  found;
      logic [OffsetBits-1:0] offset;
   } locate_type;

   typedef enum logic [1:0] {
      ReadyAlways,
      ReadyCoin,
      ReadySparse,
      ReadyPeriodic
   } ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;  // [7:0] data_byte
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OffsetBits-1:0] rsp_tdata;           // [31:0] tiff_offset
   logic                  rsp_tuser;           // [0] found

   jpeg_exif_segment_locator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Marker-walk predictor: its own copy of the window, position and the
   // position of the next marker to be judged.
   // ---------------------------------------------------------------------------
   logic [7:0]          window [0:WinLen-1];
   logic [PosBits-1:0]  byte_pos;
   logic [NextBits-1:0] marker_pos;
   logic                decided;
   locate_type          expected_results[$];

   function automatic void clear_walk();
      int i;
      for (i = 0; i < WinLen; i++) window[i] = 8'h00;
      byte_pos   = '0;
      marker_pos = FirstMarkerPos;
      decided    = 1'b0;
   endfunction

   function automatic void add_expectation(input logic found,
                                           input logic [OffsetBits-1:0] off);
      locate_type r;
      r.found  = found;
      r.offset = found ? off : '0;
      expected_results.push_back(r);
      decided = 1'b1;
   endfunction

   function automatic void locate_step(input logic [7:0] b, input logic last);
      int                 i;
      logic               bad_header;
      logic [SumBits-1:0] trigger_pos;
      logic [SumBits-1:0] next_sum;
      logic [15:0]        seg_len;
      for (i = 0; i < WinLen - 1; i++) window[i] = window[i+1];
      window[WinLen-1] = b;
      if (!decided) begin
         bad_header = 1'b0;
         if (byte_pos == PosBits'(0)) bad_header = (b != MarkerPrefix);
         else if (byte_pos == PosBits'(1)) bad_header = (b != SoiCode);
         else if (byte_pos == PosBits'(2)) bad_header = (b != MarkerPrefix);
         // The window holds the ten bytes of the marker once byte p+9 lands.
         trigger_pos = SumBits'(marker_pos) + SumBits'(9);
         if (bad_header) begin
            add_expectation(1'b0, '0);
         end else if (byte_pos != PosMax && SumBits'(byte_pos) == trigger_pos) begin
            if (window[0] != MarkerPrefix || (window[1] & AppClassMask) != AppClass) begin
               add_expectation(1'b0, '0);
            end else if (window[1] == App1Code && window[4] == CharE && window[5] == CharX &&
                         window[6] == CharI && window[7] == CharF &&
                         window[8] == CharNul && window[9] == CharNul) begin
               add_expectation(1'b1, OffsetBits'(SumBits'(marker_pos) + SumBits'(10)));
            end else begin
               // Skip the segment: big-endian length plus the two marker bytes.
               seg_len  = {window[2], window[3]};
               next_sum = SumBits'(marker_pos) + SumBits'(seg_len) + SumBits'(2);
               marker_pos = (next_sum > SumBits'(NextMax)) ? NextMax : NextBits'(next_sum);
            end
         end
      end
      if (last) begin
         if (!decided) add_expectation(1'b0, '0);
         clear_walk();
      end else if (byte_pos != PosMax) begin
         byte_pos = byte_pos + PosBits'(1);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus: buffers are built in a scratch queue, then handed to the driver
   // queue with the end flag on their final byte.
   // ---------------------------------------------------------------------------
   stream_byte_type pending_bytes[$];
   logic [7:0]      frame[$];

   function automatic void send_frame(input int keep);
      int              i;
      stream_byte_type item;
      for (i = 0; i < keep; i++) begin
         item.data = frame[i];
         item.last = (i == keep - 1);
         pending_bytes.push_back(item);
      end
   endfunction

   // Queue one whole buffer written as hex digit pairs; spaces are skipped.
   function automatic void queue_hex(input string hex);
      string digits;
      int    i;
      digits = "";
      frame.delete();
      for (i = 0; i < hex.len(); i++) begin
         if (hex[i] != 8'h20) digits = {digits, hex.substr(i, i)};
      end
      for (i = 0; i + 1 < digits.len(); i += 2) begin
         frame.push_back(8'(digits.substr(i, i + 1).atohex()));
      end
      send_frame(frame.size());
   endfunction

   function automatic logic [7:0] exif_sig_byte(input int k);
      case (k)
         0:       return CharE;
         1:       return CharX;
         2:       return CharI;
         3:       return CharF;
         default: return CharNul;
      endcase
   endfunction

   // Mostly well-formed marker chains with random content; some noise, some
   // broken headers, bad markers, short or huge lengths and cut-off buffers.
   function automatic void add_random_buffer();
      int         shape;
      int         segs;
      int         pick;
      int         seg_len;
      int         pay;
      int         cut;
      int         s;
      int         k;
      logic [7:0] code;
      frame.delete();
      shape = $urandom_range(0, 99);
      if (shape < 12) begin
         repeat ($urandom_range(1, 16)) frame.push_back(8'($urandom));
         if ($urandom_range(0, 1) == 1) frame[0] = MarkerPrefix;
         send_frame(frame.size());
         return;
      end
      frame.push_back(MarkerPrefix);
      frame.push_back(SoiCode);
      segs = $urandom_range(1, 3);
      for (s = 0; s < segs; s++) begin
         pick    = $urandom_range(0, 99);
         code    = AppClass | 8'($urandom_range(0, 15));
         seg_len = $urandom_range(8, 20);
         if (pick < 25) begin
            code = App1Code;
         end else if (pick < 33) begin
            // Anything outside the APPn class ends the walk.
            code = 8'($urandom);
            if ((code & AppClassMask) == AppClass) code = code ^ 8'h40;
         end else if (pick < 43) begin
            // Short length: the next marker overlaps bytes already seen.
            seg_len = $urandom_range(0, 7);
         end else if (pick < 48) begin
            // Length runs past the end of the buffer.
            seg_len = $urandom_range(256, 65535);
         end
         frame.push_back(MarkerPrefix);
         frame.push_back(code);
         frame.push_back(8'(seg_len >> 8));
         frame.push_back(8'(seg_len));
         pay = (seg_len >= 256) ? $urandom_range(0, 24)
                                : ((seg_len > 2) ? seg_len - 2 : 0);
         for (k = 0; k < pay; k++) begin
            if (pick < 25 && k < 6 && $urandom_range(0, 9) != 0)
               frame.push_back(exif_sig_byte(k));
            else
               frame.push_back(8'($urandom));
         end
         if (seg_len >= 256) break;
      end
      repeat ($urandom_range(0, 6)) frame.push_back(8'($urandom));
      if ($urandom_range(0, 19) == 0) frame[$urandom_range(0, 2)] = 8'($urandom);
      cut = frame.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, frame.size());
      send_frame(cut);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: present items at the falling edge in bursts separated by gaps.
   // An item stays on the bus until the monitor has counted its handshake.
   // ---------------------------------------------------------------------------
   int sent_count     = 0;
   int accepted_count = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   always @(negedge clock) begin
      stream_byte_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && accepted_count != sent_count) begin
         // hold the current item until it is taken
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (pending_bytes.size() > 0) begin
         item = pending_bytes.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= item.data;
         req_tlast  <= item.last;
         sent_count <= sent_count + 1;
         burst_left = burst_left - 1;
         if (burst_left <= 0) begin
            // Bursts of random length, each followed by no gap, a short gap or a long one.
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: gap_left = 0;
               9:          gap_left = $urandom_range(8, 16);
               default:    gap_left = $urandom_range(1, 4);
            endcase
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: tready follows a random mode that is redrawn when its run ends.
   // ---------------------------------------------------------------------------
   ready_mode_type ready_mode = ReadyAlways;
   int             mode_left  = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(40, 200);
      end else begin
         mode_left = mode_left - 1;
      end
      case (ready_mode)
         ReadyAlways: rsp_tready <= 1'b1;
         ReadyCoin:   rsp_tready <= 1'($urandom_range(0, 1));
         ReadySparse: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= ((mode_left % 7) < 4);
      endcase
   end

   // ---------------------------------------------------------------------------
   // Monitor: check results against the oldest expectation, then advance the
   // predictor with the item accepted at this edge.
   // ---------------------------------------------------------------------------
   int mismatches = 0;

   always @(posedge clock) begin
      locate_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= ReportLimit)
                  $display("unexpected result: found=%0b offset=%0d", rsp_tuser, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== want.offset) begin
                  mismatches++;
                  if (mismatches <= ReportLimit)
                     $display({"result mismatch: expected found=%0b offset=%0d,",
                               " got found=%0b offset=%0d"},
                              want.found, want.offset, rsp_tuser, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            locate_step(req_tdata, req_tlast);
            accepted_count <= accepted_count + 1;
         end
      end
   end

   // Drop the run if it stalls.
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("** jpeg_exif_segment_locator_top: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: build stimulus, release reset, drain, report.
   // ---------------------------------------------------------------------------
   initial begin
      clear_walk();
      // Bad first byte, also the last one: a single result, nothing more.
      queue_hex("00");
      // Bad second byte.
      queue_hex("FF 00");
      // Bad third byte, then a byte that must be ignored.
      queue_hex("FF D8 00 FF");
      // Exif APP1 as the first segment.
      queue_hex("FF D8 FF E1 00 08 45 78 69 66 00 00");
      // Buffer ends before any decision.
      queue_hex("FF D8 FF E0");
      while (pending_bytes.size() < RandomBytes) add_random_buffer();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || accepted_count != sent_count) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("** jpeg_exif_segment_locator_top: PASSED **");
      end else begin
         $display("** jpeg_exif_segment_locator_top: FAILED **");
      end
      $finish;
   end

endmodule
